// ===== hdl/thpl_pkg.sv =====
// ----------------------------------------------------------------------------
// thpl_pkg
// Shared types and constants for the position history interpolation block.
// ----------------------------------------------------------------------------
`default_nettype none
package thpl_pkg;

    localparam int CLIENTS_DEF = 64;
    localparam int HISTORY_DEF = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0]  MIN_SPACING_RST = 8'd5;
    localparam logic [15:0] STALE_LIMIT_RST = 16'd200;

    localparam logic [1:0] FUNC_RECORD   = 2'd0;
    localparam logic [1:0] FUNC_RETRIEVE = 2'd1;
    localparam logic [1:0] FUNC_LIFT     = 2'd2;

    localparam logic [1:0] KIND_RECORD = 2'd0;
    localparam logic [1:0] KIND_FETCH  = 2'd1;
    localparam logic [1:0] KIND_LIFT   = 2'd2;
    localparam logic [1:0] KIND_MISS   = 2'd3;

    localparam logic CFG_MIN_SPACING = 1'b0;
    localparam logic CFG_STALE_LIMIT = 1'b1;

    typedef struct packed {
        logic [1:0]         func;
        logic [5:0]         client;
        logic [30:0]        stamp;
        logic               teleport_bit;
        logic               connected;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic signed [23:0] out_x;
        logic signed [23:0] out_y;
        logic signed [23:0] out_z;
        logic               lift_moved;
        logic [30:0]        entry_time;
    } t_out_item;

    typedef struct packed {
        logic [1:0] kind;
        t_in_item   item;
    } t_qent;

    typedef struct packed {
        logic [30:0]        etime;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic [7:0]         tag;
    } t_rent;

endpackage
`default_nettype wire

// ===== hdl/timestamped_position_history_lerp.sv =====
// A retrieve walks back over the ring entries (up to HISTORY) and, when it
// finds a bracketing pair, interpolates each of the three axes in turn.
// Throughput: one request at a time in the engine, set by the walk over the
// single-port history ring and the shared 25-step restoring divider.
// A 4-deep queue decouples input acceptance from the engine.
// Reset: synchronous; clears client valid bits at once, no clearing pass.
// ----------------------------------------------------------------------------
// timestamped_position_history_lerp
// Per-client timestamped position history with interpolated lookup.
// ----------------------------------------------------------------------------
`default_nettype none
module timestamped_position_history_lerp import thpl_pkg::*; #(
    parameter int CLIENTS = CLIENTS_DEF,
    parameter int HISTORY = HISTORY_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  t_in_item         i_in_data,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_out_item        o_out_data,
    input  wire logic        i_out_stall,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    logic        r_min_spacing_v;
    logic [7:0]  r_min_spacing;
    logic [15:0] r_stale_limit;
    logic        push, full, q_valid, q_pop;
    t_qent       push_ent, q_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_spacing   <= MIN_SPACING_RST;
            r_stale_limit   <= STALE_LIMIT_RST;
            r_min_spacing_v <= 1'b0;
        end else if (i_cfg_we) begin
            r_min_spacing_v <= 1'b1;
            unique case (i_cfg_idx)
                CFG_MIN_SPACING: r_min_spacing <= i_cfg_data[7:0];
                default:         r_stale_limit <= i_cfg_data;
            endcase
        end
    end

    thpl_front #(.CLIENTS(CLIENTS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_ent   (push_ent),
        .i_full  (full)
    );

    thpl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_ent),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_ent)
    );

    thpl_back #(.CLIENTS(CLIENTS), .HISTORY(HISTORY)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_ent       (q_ent),
        .o_q_pop       (q_pop),
        .i_min_spacing (r_min_spacing_v ? r_min_spacing : MIN_SPACING_RST),
        .i_stale_limit (r_stale_limit),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data),
        .i_out_stall   (i_out_stall)
    );
endmodule
`default_nettype wire

// ===== hdl/thpl_queue.sv =====
// ----------------------------------------------------------------------------
// thpl_queue
// Short request queue between the classifier and the execution engine.
// ----------------------------------------------------------------------------
`default_nettype none
module thpl_queue import thpl_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_qent      i_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_qent      o_data
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    t_qent              r_mem [QUEUE_DEPTH];
    logic [PW-1:0]      r_wp, r_rp;
    logic [PW:0]        r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

// ===== hdl/thpl_front.sv =====
// ----------------------------------------------------------------------------
// thpl_front
// Input stage: accept requests, classify them and drop those with no effect.
// ----------------------------------------------------------------------------
`default_nettype none
module thpl_front import thpl_pkg::*; #(
    parameter int CLIENTS = CLIENTS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  t_in_item   i_item,
    output logic       o_stall,
    output logic       o_push,
    output t_qent      o_ent,
    input  wire logic  i_full
);
    logic       r_valid;
    t_in_item   r_item;
    logic       in_range;
    logic       keep;
    logic [1:0] kind;

    assign in_range = (32'(r_item.client) < 32'(CLIENTS));

    always_comb begin
        kind = KIND_MISS;
        keep = 1'b0;
        unique case (r_item.func)
            FUNC_RECORD: begin
                kind = KIND_RECORD;
                keep = in_range;
            end
            FUNC_RETRIEVE: begin
                kind = in_range ? KIND_FETCH : KIND_MISS;
                keep = 1'b1;
            end
            FUNC_LIFT: begin
                kind = KIND_LIFT;
                keep = in_range && r_item.connected;
            end
            default: begin
                kind = KIND_MISS;
                keep = 1'b0;
            end
        endcase
    end

    assign o_stall    = r_valid && keep && i_full;
    assign o_push     = r_valid && keep && !i_full;
    assign o_ent.kind = kind;
    assign o_ent.item = r_item;

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/thpl_back.sv =====
// ----------------------------------------------------------------------------
// thpl_back
// Execution engine: client table, history ring, walk back and interpolation.
// ----------------------------------------------------------------------------
`default_nettype none
module thpl_back import thpl_pkg::*; #(
    parameter int CLIENTS = CLIENTS_DEF,
    parameter int HISTORY = HISTORY_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  t_qent            i_q_ent,
    output logic             o_q_pop,
    input  wire logic [7:0]  i_min_spacing,
    input  wire logic [15:0] i_stale_limit,
    output logic             o_out_valid,
    output t_out_item        o_out_data,
    input  wire logic        i_out_stall
);
    localparam int CW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int SW = $clog2(HISTORY);
    localparam int FW = $clog2(HISTORY + 1);
    localparam int AW = $clog2(CLIENTS * HISTORY) > 0 ? $clog2(CLIENTS * HISTORY) : 1;
    localparam int QB = 25;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ROW   = 4'd1;
    localparam logic [3:0] S_RNEW  = 4'd2;
    localparam logic [3:0] S_RWR   = 4'd3;
    localparam logic [3:0] S_WALK  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_DINIT = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    typedef struct packed {
        logic [SW-1:0]      ws;
        logic [FW-1:0]      fill;
        logic               tseen;
        logic signed [23:0] last_z;
        logic [7:0]         lift;
    } t_crow;

    t_crow              r_cmem [CLIENTS];
    t_rent              r_rmem [CLIENTS*HISTORY];
    logic [CLIENTS-1:0] r_cvld;

    logic [3:0]         r_st, n_st;
    logic [1:0]         r_kind;
    t_in_item           r_item;
    logic [CW-1:0]      r_cidx;
    t_crow              r_rowm;
    logic               r_rowv;
    t_crow              r_row;
    t_rent              r_dout, r_base, r_next;
    logic               r_store;
    logic [SW-1:0]      r_p;
    logic [FW-1:0]      r_k;
    logic [1:0]         r_axis;
    logic signed [56:0] r_prod;
    logic [31:0]        r_rem;
    logic [QB-1:0]      r_dlo, r_q;
    logic               r_neg;
    logic [4:0]         r_cnt;
    logic [30:0]        r_num, r_den;
    t_out_item          r_res;
    logic               r_ovalid;

    t_crow              row;
    logic [CW-1:0]      cidx_q;
    logic [SW-1:0]      p_dec, ws_dec;
    logic               rd_en;
    logic [SW-1:0]      rd_slot;
    logic               cw_en, rw_en;
    t_crow              cw_data;
    logic               out_free;
    logic signed [24:0] a_sel, b_sel, dlt;
    logic [55:0]        mag;
    logic [31:0]        rem_sh;
    logic [31:0]        t0_sl;
    logic [QB-1:0]      q_fin;
    logic [25:0]        sum_fin, adj_fin;

    function automatic logic [AW-1:0] raddr(input logic [CW-1:0] c, input logic [SW-1:0] s);
        raddr = AW'(c) * AW'(HISTORY) + AW'(s);
    endfunction

    assign cidx_q   = CW'(i_q_ent.item.client);
    assign row      = r_rowv ? r_rowm : '0;
    assign p_dec    = (r_p == '0) ? SW'(HISTORY - 1) : r_p - 1'b1;
    assign ws_dec   = (row.ws == '0) ? SW'(HISTORY - 1) : row.ws - 1'b1;
    assign out_free = !r_ovalid || !i_out_stall;
    assign t0_sl    = {1'b0, r_dout.etime} + 32'(i_stale_limit);
    assign rem_sh   = {r_rem[30:0], r_dlo[QB-1]};
    assign mag      = r_prod[56] ? 56'(-r_prod) : r_prod[55:0];
    assign q_fin    = (rem_sh >= {1'b0, r_den}) ? {r_q[QB-2:0], 1'b1} : {r_q[QB-2:0], 1'b0};
    assign adj_fin  = r_neg ? 26'(-{1'b0, q_fin}) : {1'b0, q_fin};
    assign sum_fin  = 26'(a_sel) + adj_fin;

    always_comb begin
        unique case (r_axis)
            2'd0:    begin a_sel = 25'(r_base.x); b_sel = 25'(r_next.x); end
            2'd1:    begin a_sel = 25'(r_base.y); b_sel = 25'(r_next.y); end
            default: begin a_sel = 25'(r_base.z); b_sel = 25'(r_next.z); end
        endcase
        dlt = b_sel - a_sel;
    end

    always_comb begin
        n_st    = r_st;
        o_q_pop = 1'b0;
        rd_en   = 1'b0;
        rd_slot = ws_dec;
        cw_en   = 1'b0;
        cw_data = r_row;
        rw_en   = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_st    = (i_q_ent.kind == KIND_MISS) ? S_EMIT : S_ROW;
                end
            end
            S_ROW: begin
                case (r_kind)
                    KIND_LIFT: begin
                        cw_data        = row;
                        cw_data.last_z = r_item.pos_z;
                        cw_data.lift   = row.lift + 1'b1;
                        cw_en          = (row.last_z != r_item.pos_z);
                        n_st           = S_IDLE;
                    end
                    KIND_RECORD: begin
                        if (row.tseen != r_item.teleport_bit || row.fill == '0) begin
                            n_st = S_RWR;
                        end else begin
                            rd_en = 1'b1;
                            n_st  = S_RNEW;
                        end
                    end
                    default: begin
                        if (row.fill == '0) begin
                            n_st = S_EMIT;
                        end else begin
                            rd_en = 1'b1;
                            n_st  = S_WALK;
                        end
                    end
                endcase
            end
            S_RNEW: n_st = S_RWR;
            S_RWR: begin
                cw_en          = 1'b1;
                rw_en          = r_store;
                cw_data.last_z = r_item.pos_z;
                if (r_store) begin
                    cw_data.ws = (r_row.ws == SW'(HISTORY - 1)) ? '0 : r_row.ws + 1'b1;
                    if (r_row.fill != FW'(HISTORY)) cw_data.fill = r_row.fill + 1'b1;
                end
                n_st = S_IDLE;
            end
            S_WALK: begin
                if (r_k + 1'b1 < r_row.fill && r_dout.etime > r_item.stamp) begin
                    rd_en   = 1'b1;
                    rd_slot = p_dec;
                end else if (t0_sl < {1'b0, r_item.stamp}) begin
                    n_st = S_EMIT;
                end else if (r_dout.etime < r_item.stamp && r_k != '0
                             && r_next.etime > r_dout.etime) begin
                    n_st = S_MUL;
                end else begin
                    n_st = S_EMIT;
                end
            end
            S_MUL:   n_st = S_DINIT;
            S_DINIT: n_st = S_DIV;
            S_DIV: begin
                if (r_cnt == 5'(QB - 1)) begin
                    n_st = (r_axis == 2'd2) ? S_EMIT : S_MUL;
                end
            end
            S_EMIT: begin
                if (out_free) n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cw_en) r_cmem[r_cidx] <= cw_data;
        if (rw_en) begin
            r_rmem[raddr(r_cidx, r_row.ws)] <= '{etime: r_item.stamp, x: r_item.pos_x,
                y: r_item.pos_y, z: r_item.pos_z, tag: r_row.lift};
        end
        if (r_st == S_IDLE) begin
            r_rowm <= r_cmem[cidx_q];
            r_rowv <= r_cvld[cidx_q];
        end
        if (rd_en) r_dout <= r_rmem[raddr(r_cidx, rd_slot)];
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: begin
                r_item <= i_q_ent.item;
                r_kind <= i_q_ent.kind;
                r_cidx <= cidx_q;
                r_res  <= '0;
            end
            S_ROW: begin
                r_p     <= ws_dec;
                r_k     <= '0;
                r_store <= 1'b1;
                if (r_kind == KIND_RECORD && row.tseen != r_item.teleport_bit) begin
                    r_row <= '{ws: '0, fill: '0, tseen: r_item.teleport_bit,
                               last_z: row.last_z, lift: row.lift};
                end else begin
                    r_row <= row;
                end
            end
            S_RNEW: begin
                r_store <= ({1'b0, r_dout.etime} + 32'(i_min_spacing)) <= {1'b0, r_item.stamp};
            end
            S_WALK: begin
                if (r_k + 1'b1 < r_row.fill && r_dout.etime > r_item.stamp) begin
                    r_next <= r_dout;
                    r_p    <= p_dec;
                    r_k    <= r_k + 1'b1;
                end else if (!(t0_sl < {1'b0, r_item.stamp})) begin
                    r_base           <= r_dout;
                    r_axis           <= 2'd0;
                    r_num            <= r_item.stamp - r_dout.etime;
                    r_den            <= r_next.etime - r_dout.etime;
                    r_res.found      <= 1'b1;
                    r_res.out_x      <= r_dout.x;
                    r_res.out_y      <= r_dout.y;
                    r_res.out_z      <= r_dout.z;
                    r_res.lift_moved <= (r_dout.tag != r_row.lift);
                    r_res.entry_time <= r_dout.etime;
                end
            end
            S_MUL: begin
                r_prod <= 57'(dlt) * 57'(signed'({1'b0, r_num}));
            end
            S_DINIT: begin
                r_neg <= r_prod[56];
                r_rem <= 32'(mag >> QB);
                r_dlo <= mag[QB-1:0];
                r_q   <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_dlo <= {r_dlo[QB-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (rem_sh >= {1'b0, r_den}) begin
                    r_rem <= rem_sh - {1'b0, r_den};
                    r_q   <= {r_q[QB-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_q   <= {r_q[QB-2:0], 1'b0};
                end
                if (r_cnt == 5'(QB - 1)) begin
                    r_axis <= r_axis + 1'b1;
                    case (r_axis)
                        2'd0:    r_res.out_x <= sum_fin[23:0];
                        2'd1:    r_res.out_y <= sum_fin[23:0];
                        default: r_res.out_z <= sum_fin[23:0];
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_EMIT && out_free) o_out_data <= r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_cvld   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (cw_en) r_cvld[r_cidx] <= 1'b1;
            if (r_st == S_EMIT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
endmodule
`default_nettype wire
